@@ rtl/core/dbs_pkg.sv @@
// shared types, widths and codes for the double-ended queue with search
// no dependencies

package dbs_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [CNT_BITS-1:0]   count_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [2:0]            func_t;
    typedef logic [1:0]            status_t;

    localparam func_t FN_ADD_FRONT = 3'd0;
    localparam func_t FN_ADD_BACK  = 3'd1;
    localparam func_t FN_REM_FRONT = 3'd2;
    localparam func_t FN_REM_BACK  = 3'd3;
    localparam func_t FN_CONTAINS  = 3'd4;
    localparam func_t FN_REM_VALUE = 3'd5;

    localparam status_t STAT_OK    = 2'd0;
    localparam status_t STAT_EMPTY = 2'd1;
    localparam status_t STAT_FULL  = 2'd2;

    // ring slot of the entry at a given offset from the front
    function automatic idx_t ring_pos(input idx_t head, input count_t off);
        return head + off[IDX_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/dbs_ram.sv @@
// generic simple dual-port ram: one write port, one registered read port
// no dependencies

module dbs_ram #(
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 32
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/deque_bag_store.sv @@
// bounded double-ended queue with value search and removal, top level; uses dbs_pkg and dbs_ram
// each word: the update state, then reads of the front and back entries, then the result register
// contains: the scan steps through the entries from the front and stops at the first match or after the last entry
// remove value: scan to the match then shift a word a cycle towards the front to close the gap
// flow: one word at a time; the next word can be taken in the same cycle as the result is presented
// reset clears head, count and control; ring contents need no clearing

module deque_bag_store (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [31:0] item_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] front_value,
    output logic [31:0] back_value,
    output logic [6:0]  count,
    output logic        is_empty
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_READF = 3'd4;
    localparam logic [2:0] ST_READB = 3'd5;
    localparam logic [2:0] ST_LATCH = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]        state_reg, state_next;
    dbs_pkg::func_t    func_reg, func_next;
    dbs_pkg::value_t   value_reg, value_next;
    dbs_pkg::idx_t     head_reg, head_next;
    dbs_pkg::count_t   count_reg, count_next;
    dbs_pkg::count_t   idx_reg, idx_next;
    dbs_pkg::status_t  stat_reg, stat_next;
    logic              found_reg, found_next;
    dbs_pkg::value_t   front_reg, front_next;
    dbs_pkg::value_t   back_reg, back_next;

    logic              out_valid_reg, out_valid_next;
    dbs_pkg::status_t  out_status_reg, out_status_next;
    logic              out_found_reg, out_found_next;
    dbs_pkg::value_t   out_front_reg, out_front_next;
    dbs_pkg::value_t   out_back_reg, out_back_next;
    dbs_pkg::count_t   out_count_reg, out_count_next;
    logic              out_empty_reg, out_empty_next;

    logic              ram_we;
    dbs_pkg::idx_t     ram_waddr;
    dbs_pkg::value_t   ram_wdata;
    dbs_pkg::idx_t     ram_raddr;
    dbs_pkg::value_t   ram_rdata;

    dbs_pkg::count_t   idx_plus1;
    dbs_pkg::count_t   idx_plus2;
    logic              full;
    logic              empty;

    dbs_ram #(
        .ADDR_BITS (dbs_pkg::IDX_BITS),
        .DATA_BITS (dbs_pkg::VALUE_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_plus1 = idx_reg + dbs_pkg::count_t'(1);
    assign idx_plus2 = idx_reg + dbs_pkg::count_t'(2);
    assign full      = (count_reg == dbs_pkg::count_t'(dbs_pkg::DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        stat_next       = stat_reg;
        found_next      = found_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_count_next  = out_count_reg;
        out_empty_next  = out_empty_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_reg;
        ram_wdata       = value_reg;
        ram_raddr       = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    value_next = item_value[dbs_pkg::VALUE_BITS-1:0];
                    stat_next  = dbs_pkg::STAT_OK;
                    found_next = 1'b0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_READF;
                if ((func_reg inside {dbs_pkg::FN_ADD_FRONT, dbs_pkg::FN_ADD_BACK}) && full)
                begin
                    stat_next = dbs_pkg::STAT_FULL;
                end
                else
                begin
                    case (func_reg)
                        dbs_pkg::FN_ADD_FRONT:
                        begin
                            head_next  = head_reg - dbs_pkg::idx_t'(1);
                            ram_we     = 1'b1;
                            ram_waddr  = head_reg - dbs_pkg::idx_t'(1);
                            count_next = count_reg + dbs_pkg::count_t'(1);
                        end
                        dbs_pkg::FN_ADD_BACK:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = dbs_pkg::ring_pos(head_reg, count_reg);
                            count_next = count_reg + dbs_pkg::count_t'(1);
                        end
                        dbs_pkg::FN_REM_FRONT:
                        begin
                            if (empty)
                            begin
                                stat_next = dbs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_reg + dbs_pkg::idx_t'(1);
                                count_next = count_reg - dbs_pkg::count_t'(1);
                            end
                        end
                        dbs_pkg::FN_REM_BACK:
                        begin
                            if (empty)
                            begin
                                stat_next = dbs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - dbs_pkg::count_t'(1);
                            end
                        end
                        dbs_pkg::FN_CONTAINS, dbs_pkg::FN_REM_VALUE:
                        begin
                            if (empty)
                            begin
                                if (func_reg == dbs_pkg::FN_REM_VALUE)
                                begin
                                    stat_next = dbs_pkg::STAT_EMPTY;
                                end
                            end
                            else
                            begin
                                idx_next   = '0;
                                ram_raddr  = head_reg;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // read data is the entry at offset idx; prefetch the next one
                ram_raddr = dbs_pkg::ring_pos(head_reg, idx_plus1);
                if (ram_rdata == value_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_READF;
                    if (func_reg == dbs_pkg::FN_REM_VALUE)
                    begin
                        if (idx_plus1 < count_reg)
                        begin
                            state_next = ST_SHIFT;
                        end
                        else
                        begin
                            count_next = count_reg - dbs_pkg::count_t'(1);
                        end
                    end
                end
                else if (idx_plus1 == count_reg)
                begin
                    state_next = ST_READF;
                end
                else
                begin
                    idx_next = idx_plus1;
                end
            end
            ST_SHIFT:
            begin
                // move entry idx+1 into slot idx
                ram_we    = 1'b1;
                ram_waddr = dbs_pkg::ring_pos(head_reg, idx_reg);
                ram_wdata = ram_rdata;
                ram_raddr = dbs_pkg::ring_pos(head_reg, idx_plus2);
                idx_next  = idx_plus1;
                if (idx_plus2 >= count_reg)
                begin
                    count_next = count_reg - dbs_pkg::count_t'(1);
                    state_next = ST_READF;
                end
            end
            ST_READF:
            begin
                ram_raddr  = head_reg;
                state_next = ST_READB;
            end
            ST_READB:
            begin
                front_next = ram_rdata;
                ram_raddr  = dbs_pkg::ring_pos(head_reg, count_reg - dbs_pkg::count_t'(1));
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                back_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_found_next  = found_reg;
                    out_front_next  = empty ? '0 : front_reg;
                    out_back_next   = empty ? '0 : back_reg;
                    out_count_next  = count_reg;
                    out_empty_next  = empty;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        value_reg      <= value_next;
        idx_reg        <= idx_next;
        stat_reg       <= stat_next;
        found_reg      <= found_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
        out_count_reg  <= out_count_next;
        out_empty_reg  <= out_empty_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found       = out_found_reg;
    assign front_value = out_front_reg;
    assign back_value  = out_back_reg;
    assign count       = out_count_reg;
    assign is_empty    = out_empty_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dbs_pkg::count_t'(dbs_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_EXEC || state_reg == ST_SHIFT))
        else $error("ring written outside an update state");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=>
            (count_reg == $past(count_reg) && head_reg == $past(head_reg)))
        else $error("store changed without an operation");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_empty_reg == (out_count_reg == '0)))
        else $error("empty flag disagrees with count");

    a_found_op: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (found_reg && func_reg == dbs_pkg::FN_REM_VALUE))
        else $error("shift without a matched removal");

endmodule

@@ tb/sv/tb_deque_bag_store.sv @@
// self-checking testbench for deque_bag_store: directed and random operation words
// with a predicted store kept in step with every accepted word
// depends on dbs_pkg and the deque_bag_store rtl

module tb_deque_bag_store;

    import dbs_pkg::*;

    localparam func_t FN_SPARE_A    = 3'd6;
    localparam func_t FN_SPARE_B    = 3'd7;
    localparam int    IDLE_LIMIT    = 4000;
    localparam int    SETTLE_CYCLES = 80;
    localparam int    REPORT_MAX    = 10;

    typedef struct packed {
        status_t status;
        logic    found;
        value_t  front;
        value_t  back;
        count_t  count;
        logic    is_empty;
    } store_result_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    func_t       func        = FN_ADD_FRONT;
    logic [31:0] item_value  = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [6:0]  count;
    logic        is_empty;

    // predicted store
    value_t ring_mem [DEPTH];
    idx_t   head = '0;
    count_t fill = '0;

    store_result_t pending_results[$];
    value_t        value_pool [8];

    int gap_mode      = 0;
    int sink_mode     = 0;
    int stall_left    = 0;
    int mismatches    = 0;
    int words_sent    = 0;
    int results_seen  = 0;
    int full_rejects  = 0;
    int empty_rejects = 0;
    int search_hits   = 0;
    int peak_fill     = 0;

    deque_bag_store i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found       (found),
        .front_value (front_value),
        .back_value  (back_value),
        .count       (count),
        .is_empty    (is_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic idx_t slot_of(input int k);
        return head + idx_t'(k);
    endfunction

    task automatic predict_store(input func_t op, input value_t v, output store_result_t r);
        int k;
        int hit;
        r   = '0;
        hit = -1;
        for (k = 0; k < fill; k++)
        begin
            if (hit < 0 && ring_mem[slot_of(k)] == v)
                hit = k;
        end
        case (op)
            FN_ADD_FRONT:
            begin
                if (fill == DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    head = head - idx_t'(1);
                    ring_mem[head] = v;
                    fill++;
                end
            end
            FN_ADD_BACK:
            begin
                if (fill == DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    ring_mem[slot_of(int'(fill))] = v;
                    fill++;
                end
            end
            FN_REM_FRONT:
            begin
                if (fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    head = head + idx_t'(1);
                    fill--;
                end
            end
            FN_REM_BACK:
            begin
                if (fill == 0)
                    r.status = STAT_EMPTY;
                else
                    fill--;
            end
            FN_CONTAINS:
                r.found = (hit >= 0);
            FN_REM_VALUE:
            begin
                if (fill == 0)
                    r.status = STAT_EMPTY;
                else if (hit >= 0)
                begin
                    r.found = 1'b1;
                    // close the gap towards the front
                    for (k = hit; k + 1 < fill; k++)
                        ring_mem[slot_of(k)] = ring_mem[slot_of(k + 1)];
                    fill--;
                end
            end
            default: ;
        endcase
        r.count    = fill;
        r.is_empty = (fill == 0);
        if (fill != 0)
        begin
            r.front = ring_mem[slot_of(0)];
            r.back  = ring_mem[slot_of(int'(fill) - 1)];
        end
        if (r.status == STAT_FULL)
            full_rejects++;
        if (r.status == STAT_EMPTY)
            empty_rejects++;
        if (r.found)
            search_hits++;
        if (int'(fill) > peak_fill)
            peak_fill = int'(fill);
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (gap_mode == 0 || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input func_t op, input value_t v);
        store_result_t exp_r;
        int gap;
        func       <= op;
        item_value <= v;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_store(op, v, exp_r);
        pending_results.push_back(exp_r);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result %0d: %s expected %0h, got %0h", results_seen, name, expv, actv);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        store_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d arrived with no word outstanding", results_seen);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("status", 32'(exp_r.status), 32'(status));
                check_field("found", 32'(exp_r.found), 32'(found));
                check_field("front_value", exp_r.front, front_value);
                check_field("back_value", exp_r.back, back_value);
                check_field("count", 32'(exp_r.count), 32'(count));
                check_field("is_empty", 32'(exp_r.is_empty), 32'(is_empty));
            end
            results_seen++;
        end
        // result side back-pressure
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (sink_mode == 0)
            out_stall <= 1'b0;
        else
        begin
            case ($urandom_range(0, 99) / (sink_mode == 2 ? 25 : 35))
                0:       stall_left = $urandom_range(1, 3);
                1:       stall_left = (sink_mode == 2) ? $urandom_range(10, 30) : 0;
                default: stall_left = 0;
            endcase
            if ($urandom_range(0, 99) < 4)
                stall_left = $urandom_range(10, 30);
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic value_t pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return value_pool[3'($urandom_range(0, 7))];
        return $urandom();
    endfunction

    function automatic value_t search_value();
        if (fill != 0 && $urandom_range(0, 99) < 60)
            return ring_mem[slot_of($urandom_range(0, int'(fill) - 1))];
        return pick_value();
    endfunction

    function automatic func_t choose_op(input int bias);
        int roll;
        int add_w;
        int rem_w;
        roll  = $urandom_range(0, 99);
        add_w = (bias == 0) ? 55 : (bias == 1) ? 15 : 35;
        rem_w = (bias == 0) ? 15 : (bias == 1) ? 50 : 30;
        if (roll < add_w)
            return $urandom_range(0, 1) ? FN_ADD_FRONT : FN_ADD_BACK;
        if (roll < add_w + rem_w)
        begin
            case ($urandom_range(0, 2))
                0:       return FN_REM_FRONT;
                1:       return FN_REM_BACK;
                default: return FN_REM_VALUE;
            endcase
        end
        if (roll < 96)
            return FN_CONTAINS;
        return $urandom_range(0, 1) ? FN_SPARE_A : FN_SPARE_B;
    endfunction

    task automatic test_empty_store();
        send_word(FN_REM_FRONT, 32'h0);
        send_word(FN_REM_BACK, 32'hffff_ffff);
        send_word(FN_REM_VALUE, 32'h0);
        send_word(FN_CONTAINS, 32'h0);
        send_word(FN_SPARE_A, $urandom());
        send_word(FN_SPARE_B, $urandom());
    endtask

    task automatic test_end_ops();
        send_word(FN_ADD_BACK, 32'h7fff_ffff);
        send_word(FN_ADD_FRONT, 32'h8000_0000);
        send_word(FN_ADD_BACK, 32'hffff_ffff);
        send_word(FN_ADD_FRONT, 32'h0);
        send_word(FN_ADD_BACK, 32'h5555_5555);
        send_word(FN_ADD_FRONT, 32'haaaa_aaaa);
        send_word(FN_CONTAINS, 32'hffff_ffff);
        send_word(FN_CONTAINS, 32'h1234_5678);
        send_word(FN_REM_VALUE, 32'h1234_5678);
        send_word(FN_SPARE_A, 32'h0);
        send_word(FN_REM_FRONT, $urandom());
        send_word(FN_REM_BACK, $urandom());
        send_word(FN_REM_VALUE, 32'h8000_0000);
    endtask

    task automatic test_duplicates();
        send_word(FN_ADD_BACK, 32'h7);
        send_word(FN_ADD_BACK, 32'h9);
        send_word(FN_ADD_BACK, 32'h7);
        send_word(FN_REM_VALUE, 32'h7);
        send_word(FN_CONTAINS, 32'h7);
        send_word(FN_REM_VALUE, 32'h7);
        send_word(FN_CONTAINS, 32'h7);
    endtask

    task automatic test_full_store();
        int pick;
        // hold off until the block has answered everything
        wait_drained();
        gap_mode  = 1;
        sink_mode = 1;
        while (fill < DEPTH)
            send_word($urandom_range(0, 1) ? FN_ADD_FRONT : FN_ADD_BACK, pick_value());
        send_word(FN_ADD_FRONT, $urandom());
        send_word(FN_ADD_BACK, $urandom());
        send_word(FN_CONTAINS, ring_mem[slot_of(DEPTH - 1)]);
        send_word(FN_REM_VALUE, ring_mem[slot_of(DEPTH - 1)]);
        send_word(FN_REM_VALUE, ring_mem[slot_of(0)]);
        send_word(FN_REM_VALUE, ring_mem[slot_of(int'(fill) / 2)]);
        while (fill > 0)
        begin
            pick = $urandom_range(0, 2);
            if (pick == 0)
                send_word(FN_REM_FRONT, $urandom());
            else if (pick == 1)
                send_word(FN_REM_BACK, $urandom());
            else
                send_word(FN_REM_VALUE, search_value());
        end
    endtask

    task automatic test_random_mix();
        int    phase;
        int    n;
        func_t op;
        value_pool[0] = 32'h0;
        value_pool[1] = 32'hffff_ffff;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h7fff_ffff;
        for (n = 4; n < 8; n++)
            value_pool[3'(n)] = $urandom();
        for (phase = 0; phase < 6; phase++)
        begin
            gap_mode  = (phase == 0) ? 0 : 1;
            sink_mode = (phase == 0) ? 0 : (phase == 3) ? 2 : 1;
            if (phase == 3)
                wait_drained();
            for (n = 0; n < 50; n++)
            begin
                op = choose_op(phase % 3);
                if (op == FN_CONTAINS || op == FN_REM_VALUE)
                    send_word(op, search_value());
                else if (op == FN_ADD_FRONT || op == FN_ADD_BACK)
                    send_word(op, pick_value());
                else
                    send_word(op, $urandom());
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_store();
        test_end_ops();
        test_duplicates();
        test_full_store();
        test_random_mix();
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d words, checked %0d results; %0d full-store and %0d empty-store rejects",
                 words_sent, results_seen, full_rejects, empty_rejects);
        $display("%0d searches matched, store peaked at %0d entries", search_hits, peak_fill);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
